[rtl/core/fastq_record_parser_assert.svh]
// assertion macros used by the fastq record parser checker
`ifndef FASTQ_RECORD_PARSER_ASSERT_SVH
`define FASTQ_RECORD_PARSER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, idle while i_rst_n is low
`define FQP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, idle while i_rst_n is low
`define FQP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fqp_pkg.sv]
// types and constants of the fastq record parser
`default_nettype none

package fqp_pkg;

    localparam logic [7:0] CH_AT   = 8'd64;
    localparam logic [7:0] CH_PLUS = 8'd43;
    localparam logic [7:0] CH_NL   = 8'd10;

    localparam logic [1:0] KIND_DROP   = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_SEQ    = 2'd2;
    localparam logic [1:0] KIND_QUAL   = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_HEADER   = 3'd1;
    localparam logic [2:0] ERR_NO_SEQ   = 3'd2;
    localparam logic [2:0] ERR_SEP      = 3'd3;
    localparam logic [2:0] ERR_NO_QUAL  = 3'd4;
    localparam logic [2:0] ERR_MISMATCH = 3'd5;
    localparam logic [2:0] ERR_TOO_LONG = 3'd6;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SEQ    = 2'd1;
    localparam logic [1:0] PH_SEP    = 2'd2;
    localparam logic [1:0] PH_QUAL   = 2'd3;

    typedef struct packed {
        logic [7:0] symbol;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_symbol;
        logic [1:0]  kind;
        logic        record_end;
        logic [15:0] record_length;
        logic [2:0]  error;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/core/fqp_in_stage.sv]
// input register stage of the fastq record parser
`default_nettype none

module fqp_in_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire fqp_pkg::t_in_item i_item,
    input  wire                    i_take,
    output logic                   o_valid,
    output fqp_pkg::t_in_item      o_item
);
    import fqp_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

[rtl/core/fqp_step.sv]
// record state and per-byte tagging of the fastq record parser
`default_nettype none

module fqp_step #(
    parameter int unsigned MAX_LINE_LEN = 65535
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_adv,
    input  wire fqp_pkg::t_in_item i_item,
    output fqp_pkg::t_out_item     o_item
);
    import fqp_pkg::*;

    localparam int unsigned LimitInt = (MAX_LINE_LEN < 65535) ? MAX_LINE_LEN : 65535;
    localparam logic [15:0] LineLimit = 16'(LimitInt);

    logic [1:0]  r_phase, n_phase;
    logic        r_start, n_start;
    logic [15:0] r_seq, n_seq;
    logic [15:0] r_qual, n_qual;
    logic [2:0]  r_err, n_err;

    logic [1:0]  kind;
    logic        rend;
    logic [15:0] rlen;
    logic        nl;
    logic        fin;

    assign nl  = (i_item.symbol == CH_NL);
    assign fin = i_item.final_byte;

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_seq   = r_seq;
        n_qual  = r_qual;
        n_err   = r_err;
        kind    = KIND_DROP;
        rend    = 1'b0;
        rlen    = 16'd0;
        if (r_err == ERR_NONE) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_start) begin
                        if (i_item.symbol == CH_AT) begin
                            n_start = 1'b0;
                            n_qual  = 16'd1;
                        end else begin
                            n_err = ERR_HEADER;
                        end
                    end else if (nl) begin
                        n_phase = PH_SEQ;
                        n_start = 1'b1;
                        n_qual  = 16'd0;
                    end else if (r_qual >= LineLimit) begin
                        n_err = ERR_TOO_LONG;
                    end else begin
                        n_qual = r_qual + 16'd1;
                        kind   = KIND_HEADER;
                    end
                end
                PH_SEQ: begin
                    if (nl) begin
                        n_phase = PH_SEP;
                        n_start = 1'b1;
                    end else begin
                        n_start = 1'b0;
                        if (r_seq >= LineLimit) begin
                            n_err = ERR_TOO_LONG;
                        end else begin
                            n_seq = r_seq + 16'd1;
                            kind  = KIND_SEQ;
                        end
                    end
                end
                PH_SEP: begin
                    if (r_start) begin
                        if (i_item.symbol == CH_PLUS) begin
                            n_start = 1'b0;
                            n_qual  = 16'd1;
                        end else begin
                            n_err = ERR_SEP;
                        end
                    end else if (nl) begin
                        n_phase = PH_QUAL;
                        n_start = 1'b1;
                        n_qual  = 16'd0;
                    end else if (r_qual >= LineLimit) begin
                        n_err = ERR_TOO_LONG;
                    end else begin
                        n_qual = r_qual + 16'd1;
                    end
                end
                default: begin
                    if (nl) begin
                        if (r_qual != r_seq) begin
                            n_err = ERR_MISMATCH;
                        end else begin
                            rend = 1'b1;
                            rlen = r_seq;
                        end
                        n_phase = PH_HEADER;
                        n_start = 1'b1;
                        n_seq   = 16'd0;
                        n_qual  = 16'd0;
                    end else begin
                        n_start = 1'b0;
                        if (r_qual >= LineLimit) begin
                            n_err = ERR_TOO_LONG;
                        end else begin
                            n_qual = r_qual + 16'd1;
                            kind   = KIND_QUAL;
                        end
                    end
                end
            endcase

            // end of stream check on the updated line position
            if (n_err == ERR_NONE && fin) begin
                case (n_phase)
                    PH_HEADER: begin
                        if (!n_start) begin
                            n_err = ERR_NO_SEQ;
                        end
                    end
                    PH_SEQ: begin
                        n_err = n_start ? ERR_NO_SEQ : ERR_SEP;
                    end
                    PH_SEP: begin
                        n_err = n_start ? ERR_SEP : ERR_NO_QUAL;
                    end
                    default: begin
                        if (n_start) begin
                            n_err = ERR_NO_QUAL;
                        end else if (n_qual != n_seq) begin
                            n_err = ERR_MISMATCH;
                        end else begin
                            rend = 1'b1;
                            rlen = n_seq;
                        end
                    end
                endcase
            end

            if (fin) begin
                n_phase = PH_HEADER;
                n_start = 1'b1;
                n_seq   = 16'd0;
                n_qual  = 16'd0;
            end

            if (n_err != ERR_NONE) begin
                kind = KIND_DROP;
                rend = 1'b0;
                rlen = 16'd0;
            end
        end
    end

    always_comb begin
        o_item.out_symbol    = i_item.symbol;
        o_item.kind          = kind;
        o_item.record_end    = rend;
        o_item.record_length = rlen;
        o_item.error         = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_start <= 1'b1;
            r_seq   <= 16'd0;
            r_qual  <= 16'd0;
            r_err   <= ERR_NONE;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_start <= n_start;
            r_seq   <= n_seq;
            r_qual  <= n_qual;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

[rtl/core/fqp_out_stage.sv]
// result register stage of the fastq record parser
`default_nettype none

module fqp_out_stage (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  wire fqp_pkg::t_out_item i_item,
    output logic                    o_space,
    output logic                    o_valid,
    input  wire                     i_ready,
    output fqp_pkg::t_out_item      o_item
);
    import fqp_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_space) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

[rtl/core/fastq_record_parser.sv]
// path: input register, combinational tagging, result register
// throughput: one byte per cycle while the result register is not stalled
// input register and result register each hold one request
// reset: synchronous active-low i_rst_n clears the record state and sticky error
// reset takes effect with no clearing pass
`default_nettype none

module fastq_record_parser #(
    parameter int unsigned MAX_LINE_LEN = 65535
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire fqp_pkg::t_in_item i_item,
    output logic               o_valid,
    input  wire                i_ready,
    output fqp_pkg::t_out_item o_item
);
    import fqp_pkg::*;

    logic      q_valid;
    t_in_item  q_item;
    logic      out_space;
    logic      adv;
    t_out_item step_item;

    assign adv = q_valid && out_space;

    fqp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_take  (adv),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    fqp_step #(
        .MAX_LINE_LEN (MAX_LINE_LEN)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (q_item),
        .o_item  (step_item)
    );

    fqp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (q_valid),
        .i_item  (step_item),
        .o_space (out_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

[rtl/core/fqp_checker.sv]
// port-level checks of the fastq record parser and their bind
`default_nettype none

`include "fastq_record_parser_assert.svh"

module fqp_checker (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     i_valid,
    input wire                     o_ready,
    input wire fqp_pkg::t_in_item  i_item,
    input wire                     o_valid,
    input wire                     i_ready,
    input wire fqp_pkg::t_out_item o_item
);
    import fqp_pkg::*;

    logic in_stall;
    logic out_stall;
    logic out_end;
    logic out_no_end;
    logic out_err;
    logic end_kind_ok;

    assign in_stall    = i_valid && !o_ready;
    assign out_stall   = o_valid && !i_ready;
    assign out_end     = o_valid && o_item.record_end;
    assign out_no_end  = o_valid && !o_item.record_end;
    assign out_err     = o_valid && (o_item.error != ERR_NONE);
    assign end_kind_ok = (o_item.kind == KIND_DROP) || (o_item.kind == KIND_QUAL);

    `FQP_ASSERT_NEXT(a_out_hold, out_stall, o_valid && $stable(o_item), "result changed while stalled")
    `FQP_ASSERT_NOW(a_end_clean, out_end, (o_item.error == ERR_NONE) && end_kind_ok, "bad record end")
    `FQP_ASSERT_NOW(a_len_zero, out_no_end, o_item.record_length == 16'd0, "length without record end")
    `FQP_ASSERT_NOW(a_err_drop, out_err, (o_item.kind == KIND_DROP) && !o_item.record_end, "tag in error")
    `FQP_ASSERT_NEXT(a_in_hold, in_stall, i_valid && $stable(i_item), "request changed while waiting")

endmodule

bind fastq_record_parser fqp_checker u_fqp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);

`default_nettype wire

[bench/tb_fastq_record_parser.sv]
// testbench of fastq_record_parser: directed bytes, random records, byte tags and lengths checked
module tb_fastq_record_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import fqp_pkg::*;

    localparam int MAX_LEN     = 255;
    localparam int LINE_LIMIT  = (MAX_LEN < 65535) ? MAX_LEN : 65535;
    localparam int STALL_LIMIT = 2000;
    localparam logic [7:0] CH_CR = 8'd13;

    typedef struct packed {
        logic [7:0]  sym;
        logic        fin;
        logic        typed;
        logic [1:0]  kind;
        logic        rend;
        logic [15:0] rlen;
    } t_opening_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    // parser state as predicted
    logic [1:0]  cur_line = PH_HEADER;
    logic        line_fresh = 1'b1;
    logic [15:0] seq_len_cnt = '0;
    logic [15:0] qual_len_cnt = '0;
    logic [2:0]  held_error = ERR_NONE;

    t_out_item due_results[$];
    t_out_item want_result;
    t_opening_row opening_bytes [26];

    int send_idle_pct = 29;
    int recv_stall_pct = 48;
    int bytes_sent = 0;
    int results_checked = 0;
    int records_closed = 0;
    int mismatch_cnt = 0;
    int idle_cycles = 0;

    fastq_record_parser #(.MAX_LINE_LEN(MAX_LEN)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void restart_record();
        cur_line = PH_HEADER;
        line_fresh = 1'b1;
        seq_len_cnt = '0;
        qual_len_cnt = '0;
    endfunction

    function automatic bit bump_count(inout logic [15:0] cnt);
        if (32'(cnt) >= LINE_LIMIT) begin
            held_error = ERR_TOO_LONG;
            return 1'b0;
        end
        cnt = cnt + 16'd1;
        return 1'b1;
    endfunction

    function automatic void close_record(inout t_out_item r);
        if (qual_len_cnt != seq_len_cnt) begin
            held_error = ERR_MISMATCH;
        end else begin
            r.record_end = 1'b1;
            r.record_length = seq_len_cnt;
        end
        restart_record();
    endfunction

    function automatic t_out_item parse_byte(t_in_item it);
        t_out_item r;
        logic nl;
        r = '0;
        r.out_symbol = it.symbol;
        nl = (it.symbol == CH_NL);
        if (held_error == ERR_NONE) begin
            case (cur_line)
                PH_HEADER: begin
                    if (line_fresh) begin
                        if (it.symbol == CH_AT) begin
                            line_fresh = 1'b0;
                            qual_len_cnt = 16'd1;
                        end else begin
                            held_error = ERR_HEADER;
                        end
                    end else if (nl) begin
                        cur_line = PH_SEQ;
                        line_fresh = 1'b1;
                        qual_len_cnt = '0;
                    end else if (bump_count(qual_len_cnt)) begin
                        r.kind = KIND_HEADER;
                    end
                end
                PH_SEQ: begin
                    if (nl) begin
                        cur_line = PH_SEP;
                        line_fresh = 1'b1;
                    end else begin
                        line_fresh = 1'b0;
                        if (bump_count(seq_len_cnt)) r.kind = KIND_SEQ;
                    end
                end
                PH_SEP: begin
                    if (line_fresh) begin
                        if (it.symbol == CH_PLUS) begin
                            line_fresh = 1'b0;
                            qual_len_cnt = 16'd1;
                        end else begin
                            held_error = ERR_SEP;
                        end
                    end else if (nl) begin
                        cur_line = PH_QUAL;
                        line_fresh = 1'b1;
                        qual_len_cnt = '0;
                    end else begin
                        void'(bump_count(qual_len_cnt));
                    end
                end
                default: begin
                    if (nl) begin
                        close_record(r);
                    end else begin
                        line_fresh = 1'b0;
                        if (bump_count(qual_len_cnt)) r.kind = KIND_QUAL;
                    end
                end
            endcase
            // end of stream check
            if (held_error == ERR_NONE && it.final_byte) begin
                case (cur_line)
                    PH_HEADER: if (!line_fresh) held_error = ERR_NO_SEQ;
                    PH_SEQ:    held_error = line_fresh ? ERR_NO_SEQ : ERR_SEP;
                    PH_SEP:    held_error = line_fresh ? ERR_SEP : ERR_NO_QUAL;
                    default: begin
                        if (line_fresh) held_error = ERR_NO_QUAL;
                        else close_record(r);
                    end
                endcase
            end
            if (it.final_byte) restart_record();
            if (held_error != ERR_NONE) begin
                r.kind = KIND_DROP;
                r.record_end = 1'b0;
                r.record_length = '0;
            end
        end
        r.error = held_error;
        return r;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0: b = CH_AT;
            1: b = CH_PLUS;
            2: b = CH_CR;
            default: begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
            end
        endcase
        return b;
    endfunction

    function automatic int pick_len();
        return $urandom_range(0, 12);
    endfunction

    task automatic send_request(input t_in_item it, input t_out_item want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        due_results = {due_results, want};
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] sym, input logic fin);
        t_in_item it;
        it.symbol = sym;
        it.final_byte = fin;
        send_request(it, parse_byte(it));
    endtask

    // optional lead byte, random body, optional newline; fin rides on the last byte
    task automatic send_line(input logic [7:0] lead, input bit with_lead, input int body_len,
                             input bit with_nl, input bit fin_last);
        if (with_lead) send_byte(lead, fin_last && body_len == 0 && !with_nl);
        for (int i = 0; i < body_len; i++) begin
            send_byte(text_byte(), fin_last && i == body_len - 1 && !with_nl);
        end
        if (with_nl) send_byte(CH_NL, fin_last);
    endtask

    // fin_mode 0: none, 1: on the closing newline, 2: on the last quality char (the newline if there is none)
    task automatic send_record(input int hdr_body, input int seq_len, input int sep_body,
                               input int fin_mode);
        send_line(CH_AT, 1'b1, hdr_body, 1'b1, 1'b0);
        send_line(CH_AT, 1'b0, seq_len, 1'b1, 1'b0);
        send_line(CH_PLUS, 1'b1, sep_body, 1'b1, 1'b0);
        if (fin_mode == 2 && seq_len > 0) send_line(CH_AT, 1'b0, seq_len, 1'b0, 1'b1);
        else send_line(CH_AT, 1'b0, seq_len, 1'b1, fin_mode != 0);
    endtask

    task automatic run_records(input int byte_goal);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < byte_goal) begin
            send_record(pick_len(), pick_len(), pick_len(),
                        ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2));
        end
    endtask

    task automatic send_broken(input logic [2:0] aim);
        int n;
        int m;
        logic [7:0] b;
        n = $urandom_range(0, 5);
        case (aim)
            ERR_HEADER: begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_AT);
                send_byte(b, 1'b0);
            end
            ERR_NO_SEQ: begin
                send_line(CH_AT, 1'b1, n, 1'($urandom_range(0, 1)), 1'b1);
            end
            ERR_SEP: begin
                send_line(CH_AT, 1'b1, n, 1'b1, 1'b0);
                if ($urandom_range(0, 1) == 0) begin
                    send_line(CH_AT, 1'b0, n + 1, 1'($urandom_range(0, 1)), 1'b1);
                end else begin
                    send_line(CH_AT, 1'b0, n, 1'b1, 1'b0);
                    do b = 8'($urandom_range(0, 255)); while (b == CH_PLUS);
                    send_byte(b, 1'b0);
                end
            end
            ERR_NO_QUAL: begin
                send_line(CH_AT, 1'b1, n, 1'b1, 1'b0);
                send_line(CH_AT, 1'b0, n, 1'b1, 1'b0);
                send_line(CH_PLUS, 1'b1, n, 1'($urandom_range(0, 1)), 1'b1);
            end
            ERR_MISMATCH: begin
                send_line(CH_AT, 1'b1, n, 1'b1, 1'b0);
                send_line(CH_AT, 1'b0, n, 1'b1, 1'b0);
                send_line(CH_PLUS, 1'b1, 0, 1'b1, 1'b0);
                m = n + $urandom_range(1, 3);
                if (n > 0 && $urandom_range(0, 1) == 0) m = $urandom_range(0, n - 1);
                send_line(CH_AT, 1'b0, m, 1'b1, 1'($urandom_range(0, 1)));
            end
            ERR_TOO_LONG: begin
                send_line(CH_AT, 1'b1, n, 1'b1, 1'b0);
                send_line(CH_AT, 1'b0, LINE_LIMIT + 1 + n, 1'b0, 1'b0);
            end
            default: ;
        endcase
        // everything after the error is dropped
        repeat (24) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                $error("result with no request pending: out_symbol %0d", o_item.out_symbol);
                mismatch_cnt++;
            end else begin
                want_result = due_results.pop_front();
                results_checked++;
                if (want_result.record_end) records_closed++;
                if (o_item.out_symbol !== want_result.out_symbol) begin
                    $error("out_symbol: expected %0d, got %0d",
                           want_result.out_symbol, o_item.out_symbol);
                    mismatch_cnt++;
                end
                if (o_item.kind !== want_result.kind) begin
                    $error("kind: expected %0d, got %0d", want_result.kind, o_item.kind);
                    mismatch_cnt++;
                end
                if (o_item.record_end !== want_result.record_end) begin
                    $error("record_end: expected %0d, got %0d",
                           want_result.record_end, o_item.record_end);
                    mismatch_cnt++;
                end
                if (o_item.record_length !== want_result.record_length) begin
                    $error("record_length: expected %0d, got %0d",
                           want_result.record_length, o_item.record_length);
                    mismatch_cnt++;
                end
                if (o_item.error !== want_result.error) begin
                    $error("error: expected %0d, got %0d", want_result.error, o_item.error);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results pending",
                     idle_cycles, due_results.size());
            $display("tb_fastq_record_parser failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_in_item   it;
        t_out_item  want;
        logic [2:0] aim;

        opening_bytes = '{
            '{CH_AT,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{8'hFF,   1'b0, 1'b1, KIND_HEADER, 1'b0, 16'd0},
            '{CH_CR,   1'b0, 1'b1, KIND_HEADER, 1'b0, 16'd0},
            '{CH_NL,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{8'h00,   1'b0, 1'b1, KIND_SEQ,    1'b0, 16'd0},
            '{8'hFF,   1'b0, 1'b1, KIND_SEQ,    1'b0, 16'd0},
            '{CH_NL,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{CH_PLUS, 1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{8'h00,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{CH_NL,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{8'hFF,   1'b0, 1'b1, KIND_QUAL,   1'b0, 16'd0},
            '{CH_CR,   1'b0, 1'b1, KIND_QUAL,   1'b0, 16'd0},
            '{CH_NL,   1'b0, 1'b0, KIND_DROP,   1'b0, 16'd0},
            // bare header, empty sequence and quality
            '{CH_AT,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{CH_NL,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{CH_NL,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{CH_PLUS, 1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{CH_NL,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{CH_NL,   1'b0, 1'b0, KIND_DROP,   1'b0, 16'd0},
            // stream ends on a quality char
            '{CH_AT,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{CH_NL,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{CH_AT,   1'b0, 1'b1, KIND_SEQ,    1'b0, 16'd0},
            '{CH_NL,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{CH_PLUS, 1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{CH_NL,   1'b0, 1'b1, KIND_DROP,   1'b0, 16'd0},
            '{CH_PLUS, 1'b1, 1'b0, KIND_DROP,   1'b0, 16'd0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        restart_record();
        held_error = ERR_NONE;

        foreach (opening_bytes[r]) begin
            it.symbol = opening_bytes[r].sym;
            it.final_byte = opening_bytes[r].fin;
            want = parse_byte(it);
            if (opening_bytes[r].typed) begin
                want.kind = opening_bytes[r].kind;
                want.record_end = opening_bytes[r].rend;
                want.record_length = opening_bytes[r].rlen;
                want.error = ERR_NONE;
            end
            send_request(it, want);
        end

        run_records(110);
        send_idle_pct = 48;
        recv_stall_pct = 29;
        run_records(110);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_records(110);

        aim = 3'($urandom_range(ERR_HEADER, ERR_TOO_LONG));
        send_broken(aim);
        i_valid <= 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("%0d bytes checked over three idle patterns, %0d records closed",
                 results_checked, records_closed);
        $display("stream broken toward error %0d, sticky error seen %0d", aim, held_error);
        if (mismatch_cnt == 0 && due_results.size() == 0) begin
            $display("tb_fastq_record_parser passed");
        end else begin
            $display("tb_fastq_record_parser failed");
        end
        $finish;
    end

endmodule
